// ===== rtl/bctm_pkg.sv =====
// Shared types, constants and codes for the battery charge and temperature monitor.
// Used by bctm_ntc_search and battery_charge_temp_monitor; depends on nothing.
package bctm_pkg;

   // Sizing
   localparam int VOLT_WINDOW = 8;
   localparam int TEMP_WINDOW = 8;
   localparam int NTC_ENTRIES = 128;

   localparam int RAW_W   = 12;
   localparam int MV_W    = 16;
   localparam int CFG_W   = 16;
   localparam int OFS_W   = 8;
   localparam int SLOT_W  = 8;
   localparam int PCT_W   = 17;
   localparam int TEMP_W  = 9;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;

   // Largest scaled reading: 4095 counts is 33330 mV
   localparam int MV_MAX = 33330;
   localparam int RAW_MAX = 4095;

   // Fixed-point scaling: mv = floor(raw * 6666 / 819) = (raw * SCALE_MULT) >> SCALE_SHIFT
   localparam int SCALE_SHIFT = 24;
   localparam longint SCALE_MULT_L = (longint'(6666) * (longint'(1) << SCALE_SHIFT) + 818) / 819;
   localparam int SCALE_MULT_W = $clog2(SCALE_MULT_L + 1);
   localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = SCALE_MULT_W'(SCALE_MULT_L);
   localparam int PROD_W = RAW_W + SCALE_MULT_W;

   // Window bookkeeping
   localparam int VTOTAL_W = $clog2(VOLT_WINDOW * MV_MAX + 1);
   localparam int TTOTAL_W = $clog2(TEMP_WINDOW * RAW_MAX + 1);
   localparam int VSLOT_W  = (VOLT_WINDOW > 1) ? $clog2(VOLT_WINDOW) : 1;
   localparam int TSLOT_W  = (TEMP_WINDOW > 1) ? $clog2(TEMP_WINDOW) : 1;
   localparam int WIN_DEPTH = VOLT_WINDOW + TEMP_WINDOW;
   localparam int WADDR_W  = $clog2(WIN_DEPTH);

   // NTC table and search
   localparam int NIDX_W = $clog2(NTC_ENTRIES);
   localparam int SRCH_W = $clog2(NTC_ENTRIES + 1) + 1;
   localparam logic [NIDX_W-1:0] NTC_LAST = NIDX_W'(NTC_ENTRIES - 1);

   // Register reset values
   localparam logic [CFG_W-1:0] CHARGE_OVP_RST    = 16'd5500;
   localparam logic [CFG_W-1:0] CHARGE_NORMAL_RST = 16'd4450;
   localparam logic [CFG_W-1:0] CHARGE_LOW_RST    = 16'd500;
   localparam logic [CFG_W-1:0] BATTERY_OVP_RST   = 16'd4200;
   localparam logic [CFG_W-1:0] BATTERY_NORMAL_RST = 16'd3700;
   localparam logic [CFG_W-1:0] BATTERY_LOW_RST   = 16'd3500;
   localparam logic [OFS_W-1:0] TEMP_OFFSET_RST   = 8'd44;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHARGE_OVP     = 3'd0,
      CSR_CHARGE_NORMAL  = 3'd1,
      CSR_CHARGE_LOW     = 3'd2,
      CSR_BATTERY_OVP    = 3'd3,
      CSR_BATTERY_NORMAL = 3'd4,
      CSR_BATTERY_LOW    = 3'd5,
      CSR_TEMP_OFFSET    = 3'd6
   } csr_index_type;

   // Request kinds
   localparam logic REQ_SAMPLE    = 1'b0;
   localparam logic REQ_TABLE_WR  = 1'b1;

   // Classification codes
   localparam logic [1:0] CHG_IDLE   = 2'd0;
   localparam logic [1:0] CHG_OVP    = 2'd1;
   localparam logic [1:0] CHG_NORMAL = 2'd2;
   localparam logic [1:0] CHG_LOW    = 2'd3;
   localparam logic [1:0] BAT_VERY_LOW = 2'd0;
   localparam logic [1:0] BAT_OVP      = 2'd1;
   localparam logic [1:0] BAT_NORMAL   = 2'd2;
   localparam logic [1:0] BAT_LOW      = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE_C,
      ST_SCALE_B,
      ST_VOLT,
      ST_TEMP,
      ST_SEARCH,
      ST_DONE
   } top_state_type;

   typedef enum logic [2:0] {
      SRCH_IDLE,
      SRCH_LO,
      SRCH_HI,
      SRCH_PROBE,
      SRCH_CMP
   } srch_state_type;

   // Table write from the top level
   typedef struct packed {
      logic              en;
      logic [NIDX_W-1:0] slot;
      logic [RAW_W-1:0]  word;
   } ntc_wr_type;

   // Search result back to the top level
   typedef struct packed {
      logic              done;
      logic [NIDX_W-1:0] index;
   } srch_status_type;

endpackage

// ===== rtl/bctm_ntc_search.sv =====
// NTC table memory and binary search for the index of an averaged thermistor reading.
// Depends on bctm_pkg.
module bctm_ntc_search
   import bctm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  ntc_wr_type            ntc_wr,
   input  logic                  start,
   input  logic [RAW_W-1:0]      avg,
   output srch_status_type       status
);

   logic [RAW_W-1:0]  ntc_mem [NTC_ENTRIES];
   logic [RAW_W-1:0]  ntc_q_ff;
   logic [NIDX_W-1:0] rd_addr;

   srch_state_type state_ff, state_in;
   logic signed [SRCH_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [NIDX_W-1:0] mid_ff, mid_in, idx_ff, idx_in;
   logic done_ff, done_in;

   logic signed [SRCH_W:0]   mid_sum;
   logic [NIDX_W-1:0]        mid_now;
   logic signed [SRCH_W-1:0] mid_ext;

   // Midpoint of the live range; both bounds are non-negative while probing
   assign mid_sum = {lo_ff[SRCH_W-1], lo_ff} + {hi_ff[SRCH_W-1], hi_ff};
   assign mid_now = mid_sum[NIDX_W:1];
   assign mid_ext = $signed({{(SRCH_W-NIDX_W){1'b0}}, mid_ff});

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ntc_wr.en) begin
         ntc_mem[ntc_wr.slot] <= ntc_wr.word;
      end
      ntc_q_ff <= ntc_mem[rd_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SRCH_IDLE:  if (start) state_in = SRCH_LO;
         SRCH_LO:    state_in = (avg <= ntc_q_ff) ? SRCH_IDLE : SRCH_HI;
         SRCH_HI:    state_in = (avg >= ntc_q_ff) ? SRCH_IDLE : SRCH_PROBE;
         SRCH_PROBE: state_in = (lo_ff <= hi_ff) ? SRCH_CMP : SRCH_IDLE;
         SRCH_CMP:   state_in = (avg == ntc_q_ff) ? SRCH_IDLE : SRCH_PROBE;
         default:    state_in = SRCH_IDLE;
      endcase
   end

   // Datapath and read address
   always_comb begin
      rd_addr = '0;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      mid_in  = mid_ff;
      idx_in  = idx_ff;
      done_in = 1'b0;
      case (state_ff)
         SRCH_IDLE: begin
            rd_addr = '0;
         end
         SRCH_LO: begin
            // At or below the first entry
            if (avg <= ntc_q_ff) begin
               idx_in  = '0;
               done_in = 1'b1;
            end else begin
               rd_addr = NTC_LAST;
            end
         end
         SRCH_HI: begin
            // At or above the last entry
            if (avg >= ntc_q_ff) begin
               idx_in  = NTC_LAST;
               done_in = 1'b1;
            end else begin
               lo_in = '0;
               hi_in = $signed({{(SRCH_W-NIDX_W){1'b0}}, NTC_LAST});
            end
         end
         SRCH_PROBE: begin
            if (lo_ff <= hi_ff) begin
               rd_addr = mid_now;
               mid_in  = mid_now;
            end else begin
               // Range closed without a hit: final upper bound, clamped at zero
               idx_in  = hi_ff[SRCH_W-1] ? '0 : hi_ff[NIDX_W-1:0];
               done_in = 1'b1;
            end
         end
         SRCH_CMP: begin
            if (avg == ntc_q_ff) begin
               idx_in  = mid_ff;
               done_in = 1'b1;
            end else if (avg < ntc_q_ff) begin
               hi_in = mid_ext - SRCH_W'(1);
            end else begin
               lo_in = mid_ext + SRCH_W'(1);
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRCH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Search bounds and result
   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      idx_ff <= idx_in;
   end

   assign status.done  = done_ff;
   assign status.index = idx_ff;

endmodule

// ===== rtl/battery_charge_temp_monitor.sv =====
// Battery charge and temperature monitor, top level.
// Depends on bctm_pkg and bctm_ntc_search.
//
// Usage:
//   req_* carries either a sample (three ADC readings) or one NTC table entry,
//   selected by req_tuser. Table entries must be loaded before samples.
//   rsp_* returns one result per sample; table writes return nothing.
//   csr_* writes the thresholds and the temperature index offset; write only
//   while no sample is in flight.
// Timing:
//   A table write goes into the table memory as it is accepted. A sample
//   passes scaling and window update through the window memory (states
//   ST_SCALE_C, ST_SCALE_B, ST_VOLT, ST_TEMP), then the NTC binary search,
//   each probe a read through the single table read port, then a compare.
//   One sample is processed at a time; req_tready is high in idle.
// Reset:
//   Synchronous; clears both windows and their sums, restores register
//   defaults. The NTC table content is kept and undefined until written.
// Back-pressure:
//   A finished result sits in the output register; a new request is taken
//   meanwhile, and the next result waits until the previous one transfers.
module battery_charge_temp_monitor
   import bctm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // charge_raw[11:0], battery_raw[23:12], temp_raw[35:24],
   // table_slot[43:36], table_word[55:44]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                  req_tuser,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // charge_mv[15:0], charge_state[17:16], battery_mv[33:18],
   // battery_state[35:34], charge_percent_x100[52:36], temperature_c[61:53], zero[63:62]
   output logic [RSP_DATA_W-1:0] rsp_tdata,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   // Request fields
   logic [RAW_W-1:0]  charge_raw, battery_raw, temp_raw, table_word;
   logic [SLOT_W-1:0] table_slot;
   logic              req_xfer;

   assign charge_raw  = req_tdata[11:0];
   assign battery_raw = req_tdata[23:12];
   assign temp_raw    = req_tdata[35:24];
   assign table_slot  = req_tdata[43:36];
   assign table_word  = req_tdata[55:44];
   assign req_xfer    = req_tvalid && req_tready;

   // Configuration registers
   logic [CFG_W-1:0] charge_ovp_ff, charge_normal_ff, charge_low_ff;
   logic [CFG_W-1:0] battery_ovp_ff, battery_normal_ff, battery_low_ff;
   logic [OFS_W-1:0] temp_offset_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_ovp_ff     <= CHARGE_OVP_RST;
         charge_normal_ff  <= CHARGE_NORMAL_RST;
         charge_low_ff     <= CHARGE_LOW_RST;
         battery_ovp_ff    <= BATTERY_OVP_RST;
         battery_normal_ff <= BATTERY_NORMAL_RST;
         battery_low_ff    <= BATTERY_LOW_RST;
         temp_offset_ff    <= TEMP_OFFSET_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHARGE_OVP:     charge_ovp_ff     <= csr_data;
            CSR_CHARGE_NORMAL:  charge_normal_ff  <= csr_data;
            CSR_CHARGE_LOW:     charge_low_ff     <= csr_data;
            CSR_BATTERY_OVP:    battery_ovp_ff    <= csr_data;
            CSR_BATTERY_NORMAL: battery_normal_ff <= csr_data;
            CSR_BATTERY_LOW:    battery_low_ff    <= csr_data;
            CSR_TEMP_OFFSET:    temp_offset_ff    <= csr_data[OFS_W-1:0];
            default:            temp_offset_ff    <= temp_offset_ff;
         endcase
      end
   end

   // Sequencer and datapath registers
   top_state_type state_ff, state_in;
   logic [RAW_W-1:0]    craw_ff, braw_ff, traw_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [MV_W-1:0]     cmv_ff;
   logic [MV_W-1:0]     old_v_ff;
   logic [VTOTAL_W-1:0] vtotal_ff;
   logic [TTOTAL_W-1:0] ttotal_ff;
   logic [VSLOT_W-1:0]  vslot_ff;
   logic [TSLOT_W-1:0]  tslot_ff;

   // Window memory: battery entries first, thermistor entries after
   logic [MV_W-1:0]      win_mem [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] win_valid_ff;
   logic [MV_W-1:0]      win_q_ff;
   logic                 win_qv_ff;
   logic [WADDR_W-1:0]   win_rd_addr, win_wr_addr, vaddr, taddr;
   logic [MV_W-1:0]      win_wr_data;
   logic                 win_we;
   logic [MV_W-1:0]      win_old;

   // Scaling multiplier, shared by both voltage readings
   logic [RAW_W-1:0]  mul_a;
   logic [PROD_W-1:0] mul_p;
   logic [MV_W-1:0]   prod_mv;

   // Search hookup
   ntc_wr_type      ntc_wr;
   srch_status_type srch;
   logic            srch_start;

   // Averages and result
   logic [VTOTAL_W-1:0] vavg_full;
   logic [TTOTAL_W-1:0] tavg_full;
   logic [MV_W-1:0]     bmv;
   logic [RAW_W-1:0]    tavg;
   logic [1:0]          cst, bst;
   logic [MV_W+1:0]     bmv_x5;
   logic [TEMP_W-1:0]   temp_c;
   logic                rsp_load;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]     rsp_cmv_ff, rsp_bmv_ff;
   logic [1:0]          rsp_cst_ff, rsp_bst_ff;
   logic [PCT_W-1:0]    rsp_pct_ff;
   logic [TEMP_W-1:0]   rsp_temp_ff;

   assign vaddr = WADDR_W'(vslot_ff);
   assign taddr = WADDR_W'(VOLT_WINDOW) + WADDR_W'(tslot_ff);

   assign mul_a   = (state_ff == ST_SCALE_C) ? craw_ff : braw_ff;
   assign mul_p   = PROD_W'(mul_a) * PROD_W'(SCALE_MULT);
   assign prod_mv = prod_ff[SCALE_SHIFT +: MV_W];

   // Entries never written since reset read as zero
   assign win_old = win_qv_ff ? win_q_ff : '0;

   assign vavg_full = vtotal_ff / VTOTAL_W'(VOLT_WINDOW);
   assign tavg_full = ttotal_ff / TTOTAL_W'(TEMP_WINDOW);
   assign bmv  = vavg_full[MV_W-1:0];
   assign tavg = tavg_full[RAW_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (req_xfer && req_tuser == REQ_SAMPLE) state_in = ST_SCALE_C;
         ST_SCALE_C: state_in = ST_SCALE_B;
         ST_SCALE_B: state_in = ST_VOLT;
         ST_VOLT:    state_in = ST_TEMP;
         ST_TEMP:    state_in = ST_SEARCH;
         ST_SEARCH:  if (srch.done) state_in = ST_DONE;
         ST_DONE:    if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      win_rd_addr = vaddr;
      win_we      = 1'b0;
      win_wr_addr = vaddr;
      win_wr_data = prod_mv;
      srch_start  = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_SCALE_C: win_rd_addr = vaddr;
         ST_SCALE_B: win_rd_addr = taddr;
         ST_VOLT: begin
            win_we      = 1'b1;
            win_wr_addr = vaddr;
            win_wr_data = prod_mv;
         end
         ST_TEMP: begin
            win_we      = 1'b1;
            win_wr_addr = taddr;
            win_wr_data = MV_W'(traw_ff);
            srch_start  = 1'b1;
         end
         ST_DONE:  rsp_load = !rsp_valid_ff || rsp_tready;
         default:  win_we = 1'b0;
      endcase
   end

   // Table writes go straight to the search unit; out-of-range slots are dropped
   always_comb begin
      ntc_wr.en   = req_xfer && (req_tuser == REQ_TABLE_WR) &&
                    ({1'b0, table_slot} < (SLOT_W+1)'(NTC_ENTRIES));
      ntc_wr.slot = table_slot[NIDX_W-1:0];
      ntc_wr.word = table_word;
   end

   bctm_ntc_search u_search (
      .clock  (clock),
      .reset  (reset),
      .ntc_wr (ntc_wr),
      .start  (srch_start),
      .avg    (tavg),
      .status (srch)
   );

   // Window memory, registered read
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_wr_addr] <= win_wr_data;
      end
      win_q_ff <= win_mem[win_rd_addr];
   end

   // Window control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_valid_ff <= '0;
         win_qv_ff    <= 1'b0;
         vtotal_ff    <= '0;
         ttotal_ff    <= '0;
         vslot_ff     <= '0;
         tslot_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         win_qv_ff <= win_valid_ff[win_rd_addr];
         if (win_we) begin
            win_valid_ff[win_wr_addr] <= 1'b1;
         end
         // Running sums: drop the oldest entry, add the newest
         if (state_ff == ST_VOLT) begin
            vtotal_ff <= vtotal_ff - VTOTAL_W'(old_v_ff) + VTOTAL_W'(prod_mv);
            ttotal_ff <= ttotal_ff - TTOTAL_W'(win_old) + TTOTAL_W'(traw_ff);
            vslot_ff  <= (vslot_ff == VSLOT_W'(VOLT_WINDOW - 1)) ? '0 : vslot_ff + 1'b1;
         end
         if (state_ff == ST_TEMP) begin
            tslot_ff <= (tslot_ff == TSLOT_W'(TEMP_WINDOW - 1)) ? '0 : tslot_ff + 1'b1;
         end
      end
   end

   // Sample capture and scaling pipeline
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         craw_ff <= charge_raw;
         braw_ff <= battery_raw;
         traw_ff <= temp_raw;
      end
      if (state_ff == ST_SCALE_C || state_ff == ST_SCALE_B) begin
         prod_ff <= mul_p;
      end
      if (state_ff == ST_SCALE_B) begin
         cmv_ff   <= prod_mv;
         old_v_ff <= win_old;
      end
   end

   // Classification
   always_comb begin
      if (cmv_ff >= charge_ovp_ff) begin
         cst = CHG_OVP;
      end else if (cmv_ff >= charge_normal_ff) begin
         cst = CHG_NORMAL;
      end else if (cmv_ff >= charge_low_ff) begin
         cst = CHG_LOW;
      end else begin
         cst = CHG_IDLE;
      end
      if (bmv > battery_ovp_ff) begin
         bst = BAT_OVP;
      end else if (bmv >= battery_normal_ff) begin
         bst = BAT_NORMAL;
      end else if (bmv >= battery_low_ff) begin
         bst = BAT_LOW;
      end else begin
         bst = BAT_VERY_LOW;
      end
   end

   // State of charge: mv * 5 / 2; temperature: index minus offset
   assign bmv_x5 = {bmv, 2'b00} + {2'b00, bmv};
   assign temp_c = TEMP_W'(srch.index) - TEMP_W'(temp_offset_ff);

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cmv_ff  <= cmv_ff;
         rsp_cst_ff  <= cst;
         rsp_bmv_ff  <= bmv;
         rsp_bst_ff  <= bst;
         rsp_pct_ff  <= bmv_x5[PCT_W:1];
         rsp_temp_ff <= temp_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_temp_ff, rsp_pct_ff, rsp_bst_ff, rsp_bmv_ff,
                        rsp_cst_ff, rsp_cmv_ff};

endmodule

// ===== bench/tb_battery_charge_temp_monitor.sv =====
// Self-checking bench for battery_charge_temp_monitor: table-driven directed samples,
// then random sample runs checked against an in-bench predictor of scaling, averaging
// and NTC lookup. Depends on bctm_pkg and the RTL of the monitor.
`timescale 1ns / 100ps

module tb_battery_charge_temp_monitor;
   import bctm_pkg::*;

   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 340;
   localparam int TIMEOUT_NS     = 5_000_000;
   localparam int REPORT_LIMIT   = 10;

   // Request payload, first field in the low bits
   typedef struct packed {
      logic [RAW_W-1:0]  table_word;
      logic [SLOT_W-1:0] table_slot;
      logic [RAW_W-1:0]  temp_raw;
      logic [RAW_W-1:0]  battery_raw;
      logic [RAW_W-1:0]  charge_raw;
   } req_fields_t;

   // Result payload, first field in the low bits
   typedef struct packed {
      logic [1:0]        pad;
      logic [TEMP_W-1:0] temperature_c;
      logic [PCT_W-1:0]  charge_percent_x100;
      logic [1:0]        battery_state;
      logic [MV_W-1:0]   battery_mv;
      logic [1:0]        charge_state;
      logic [MV_W-1:0]   charge_mv;
   } reading_t;

   typedef struct {
      logic              kind;
      logic [RAW_W-1:0]  charge;
      logic [RAW_W-1:0]  batt;
      logic [RAW_W-1:0]  temp;
      logic [SLOT_W-1:0] slot;
      logic [RAW_W-1:0]  word;
      bit                typed;
      logic [MV_W-1:0]   w_cmv;
      logic [1:0]        w_cst;
      logic [MV_W-1:0]   w_bmv;
      logic [1:0]        w_bst;
      logic [PCT_W-1:0]  w_pct;
      logic [TEMP_W-1:0] w_temp;
   } stim_row_t;

   typedef enum {LIM_TYPICAL, LIM_ZERO, LIM_MAX, LIM_SPREAD, LIM_WIDE} limit_style_t;
   typedef enum {TBL_KEEP, TBL_RISING, TBL_STEPPED, TBL_SCRAMBLED} table_style_t;
   typedef enum {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;

   // DUT connections
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // charge_raw, battery_raw, temp_raw, table_slot, table_word (low bits first)
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // req_type
   logic                  req_tuser = REQ_SAMPLE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // charge_mv, charge_state, battery_mv, battery_state, charge_percent_x100,
   // temperature_c, zero pad (low bits first)
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_data = '0;

   // Predictor state
   logic [MV_W-1:0]     volt_hist [VOLT_WINDOW];
   logic [VTOTAL_W-1:0] volt_sum = '0;
   logic [VSLOT_W-1:0]  volt_ptr = '0;
   logic [RAW_W-1:0]    temp_hist [TEMP_WINDOW];
   logic [TTOTAL_W-1:0] temp_sum = '0;
   logic [TSLOT_W-1:0]  temp_ptr = '0;
   logic [RAW_W-1:0]    ntc_copy [NTC_ENTRIES];
   logic [CFG_W-1:0]    limit_copy [7];

   reading_t pending_readings [$];
   reading_t seen_reading, wanted_reading;
   int       mismatches = 0;
   int       items_sent = 0;
   int       send_idle_pct = 0;
   int       recv_idle_pct = 0;
   int       hold_trigger = 0;
   int       hold_seen = 0;
   int       hold_count = 0;

   limit_style_t phase_limits [6] =
      '{LIM_TYPICAL, LIM_ZERO, LIM_MAX, LIM_SPREAD, LIM_WIDE, LIM_TYPICAL};
   table_style_t phase_tables [6] =
      '{TBL_KEEP, TBL_STEPPED, TBL_KEEP, TBL_SCRAMBLED, TBL_RISING, TBL_KEEP};
   idle_mode_t   phase_idles  [6] =
      '{IDLE_SENDER_LIGHT, IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY,
        IDLE_SENDER_HEAVY, IDLE_NONE, IDLE_NONE};

   // Directed samples; expectations typed only where obvious at reset thresholds
   stim_row_t directed_rows [20] = '{
      // kind       charge   batt     temp     slot     word     typed  cmv       cst
      //                                                                bmv       bst
      //                                                                pct       temp
      // all-zero readings: everything at the bottom, index 0 less the offset
      '{REQ_SAMPLE,   12'd0,    12'd0,    12'd0,    8'd0,   12'd0,   1'b1,
        16'd0,     CHG_IDLE,  16'd0,     BAT_VERY_LOW, 17'd0,     -9'sd44},
      // full-scale charger reading
      '{REQ_SAMPLE,   12'd4095, 12'd0,    12'd0,    8'hFF,  12'hFFF, 1'b1,
        16'd33330, CHG_OVP,   16'd0,     BAT_VERY_LOW, 17'd0,     -9'sd44},
      // charger readings on both sides of each default threshold
      '{REQ_SAMPLE,   12'd61,   12'hAAA,  12'h555,  8'h55,  12'hAAA, 1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd62,   12'h555,  12'hAAA,  8'hAA,  12'h555, 1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd546,  12'd430,  12'd1000, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd547,  12'd455,  12'd2000, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd675,  12'd516,  12'd3000, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd676,  12'd517,  12'd4000, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      // table writes past the end of the table are dropped
      '{REQ_TABLE_WR, 12'hFFF,  12'hFFF,  12'hFFF,  8'd128, 12'hFFF, 1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_TABLE_WR, 12'h000,  12'h000,  12'h000,  8'd255, 12'h000, 1'b0,
        '0, '0, '0, '0, '0, '0},
      // fill both windows with full scale
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b0,
        '0, '0, '0, '0, '0, '0},
      // windows now full scale: overvoltage, top percent, last index
      '{REQ_SAMPLE,   12'd0,    12'd4095, 12'd4095, 8'd0,   12'd0,   1'b1,
        16'd0,     CHG_IDLE,  16'd33330, BAT_OVP,      17'd83325, 9'sd83},
      // rewrite the last entry, then sample against it
      '{REQ_TABLE_WR, 12'd0,    12'd0,    12'd0,    8'd127, 12'hFFF, 1'b0,
        '0, '0, '0, '0, '0, '0},
      '{REQ_SAMPLE,   12'd4095, 12'd0,    12'd0,    8'h7F,  12'h800, 1'b0,
        '0, '0, '0, '0, '0, '0}
   };

   battery_charge_temp_monitor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Predictor initial state matches reset
   initial begin
      foreach (volt_hist[i]) volt_hist[i] = '0;
      foreach (temp_hist[i]) temp_hist[i] = '0;
      foreach (ntc_copy[i]) ntc_copy[i] = '0;
      limit_copy[CSR_CHARGE_OVP]     = CHARGE_OVP_RST;
      limit_copy[CSR_CHARGE_NORMAL]  = CHARGE_NORMAL_RST;
      limit_copy[CSR_CHARGE_LOW]     = CHARGE_LOW_RST;
      limit_copy[CSR_BATTERY_OVP]    = BATTERY_OVP_RST;
      limit_copy[CSR_BATTERY_NORMAL] = BATTERY_NORMAL_RST;
      limit_copy[CSR_BATTERY_LOW]    = BATTERY_LOW_RST;
      limit_copy[CSR_TEMP_OFFSET]    = CFG_W'(TEMP_OFFSET_RST);
   end

   function automatic int unsigned scale_to_mv(int unsigned raw);
      return (raw * 333300) / 40950;
   endfunction

   // Binary search for an entry equal to the average, else the largest one below it, clamped
   function automatic int unsigned lookup_index(int unsigned avg);
      int lo, hi, mid, idx;
      bit hit;
      lo  = 0;
      hi  = NTC_ENTRIES - 1;
      idx = 0;
      hit = 1'b0;
      if (avg <= ntc_copy[0]) return 0;
      if (avg >= ntc_copy[NTC_ENTRIES-1]) return NTC_ENTRIES - 1;
      while (lo <= hi && !hit) begin
         mid = (lo + hi) / 2;
         if (avg == ntc_copy[mid]) begin
            hit = 1'b1;
            idx = mid;
         end else if (avg < ntc_copy[mid]) begin
            hi = mid - 1;
         end else begin
            lo = mid + 1;
         end
      end
      if (!hit) idx = hi;
      if (idx < 0) idx = 0;
      if (idx > NTC_ENTRIES - 1) idx = NTC_ENTRIES - 1;
      return idx;
   endfunction

   // Reading for one sample; advances both windows
   function automatic reading_t predict_reading(req_fields_t f);
      reading_t    r;
      int unsigned new_mv, bavg, tavg, idx;
      r = '0;
      r.charge_mv = MV_W'(scale_to_mv(f.charge_raw));
      if (r.charge_mv >= limit_copy[CSR_CHARGE_OVP])         r.charge_state = CHG_OVP;
      else if (r.charge_mv >= limit_copy[CSR_CHARGE_NORMAL]) r.charge_state = CHG_NORMAL;
      else if (r.charge_mv >= limit_copy[CSR_CHARGE_LOW])    r.charge_state = CHG_LOW;
      else                                                   r.charge_state = CHG_IDLE;

      new_mv = scale_to_mv(f.battery_raw);
      volt_sum = VTOTAL_W'(volt_sum - volt_hist[volt_ptr] + new_mv);
      volt_hist[volt_ptr] = MV_W'(new_mv);
      volt_ptr = (volt_ptr == VSLOT_W'(VOLT_WINDOW - 1)) ? '0 : volt_ptr + 1'b1;
      bavg = volt_sum / VOLT_WINDOW;
      r.battery_mv = MV_W'(bavg);
      // overvoltage test is strict here
      if (bavg > limit_copy[CSR_BATTERY_OVP])         r.battery_state = BAT_OVP;
      else if (bavg >= limit_copy[CSR_BATTERY_NORMAL]) r.battery_state = BAT_NORMAL;
      else if (bavg >= limit_copy[CSR_BATTERY_LOW])    r.battery_state = BAT_LOW;
      else                                             r.battery_state = BAT_VERY_LOW;
      r.charge_percent_x100 = PCT_W'((bavg * 5) / 2);

      temp_sum = TTOTAL_W'(temp_sum - temp_hist[temp_ptr] + f.temp_raw);
      temp_hist[temp_ptr] = f.temp_raw;
      temp_ptr = (temp_ptr == TSLOT_W'(TEMP_WINDOW - 1)) ? '0 : temp_ptr + 1'b1;
      tavg = temp_sum / TEMP_WINDOW;
      idx = lookup_index(tavg);
      r.temperature_c = TEMP_W'(idx - limit_copy[CSR_TEMP_OFFSET][OFS_W-1:0]);
      return r;
   endfunction

   function automatic req_fields_t random_fields();
      req_fields_t f;
      f.charge_raw  = RAW_W'($urandom);
      f.battery_raw = RAW_W'($urandom);
      f.temp_raw    = RAW_W'($urandom);
      f.table_slot  = SLOT_W'($urandom);
      f.table_word  = RAW_W'($urandom);
      return f;
   endfunction

   // Raw reading within two counts of the raw value that scales to mv
   function automatic logic [RAW_W-1:0] raw_near_mv(int mv);
      int raw;
      if (mv > MV_MAX) raw = RAW_MAX;
      else raw = (mv * 40950 + 333299) / 333300;
      raw = raw + $urandom_range(4) - 2;
      if (raw < 0) raw = 0;
      if (raw > RAW_MAX) raw = RAW_MAX;
      return RAW_W'(raw);
   endfunction

   function automatic logic [RAW_W-1:0] temp_near_entry();
      int v;
      v = ntc_copy[$urandom_range(NTC_ENTRIES - 1)];
      v = v + $urandom_range(2) - 1;
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return RAW_W'(v);
   endfunction

   // One request transfer; sender gaps before it, predictor updated on acceptance
   task automatic send_item(input logic kind, input req_fields_t f);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
      if (kind == REQ_TABLE_WR) begin
         if (f.table_slot < NTC_ENTRIES) begin
            ntc_copy[f.table_slot] = f.table_word;
            items_sent++;
         end
      end else begin
         pending_readings.push_back(predict_reading(f));
         items_sent++;
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_TEMP_OFFSET) limit_copy[idx] = {8'd0, value[OFS_W-1:0]};
      else limit_copy[idx] = value;
   endtask

   // Stop offering requests, let every reading come back, then let the block settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_limits(input limit_style_t style);
      logic [CFG_W-1:0] v [7];
      case (style)
         LIM_TYPICAL: begin
            // thresholds sit on reachable scaled values so equality is hit
            v[CSR_CHARGE_OVP]     = CFG_W'(scale_to_mv($urandom_range(640, 760)));
            v[CSR_CHARGE_NORMAL]  = CFG_W'(scale_to_mv($urandom_range(530, 580)));
            v[CSR_CHARGE_LOW]     = CFG_W'(scale_to_mv($urandom_range(50, 80)));
            v[CSR_BATTERY_OVP]    = CFG_W'(scale_to_mv($urandom_range(500, 530)));
            v[CSR_BATTERY_NORMAL] = CFG_W'(scale_to_mv($urandom_range(450, 480)));
            v[CSR_BATTERY_LOW]    = CFG_W'(scale_to_mv($urandom_range(420, 445)));
            v[CSR_TEMP_OFFSET]    = CFG_W'($urandom_range(20, 60));
         end
         LIM_ZERO:   foreach (v[i]) v[i] = '0;
         LIM_MAX:    foreach (v[i]) v[i] = '1;
         LIM_SPREAD: begin
            foreach (v[i]) v[i] = CFG_W'($urandom_range(MV_MAX));
            v[CSR_TEMP_OFFSET] = CFG_W'($urandom_range(255));
         end
         default:    foreach (v[i]) v[i] = CFG_W'($urandom);
      endcase
      for (int i = 0; i < 7; i++) write_csr(csr_index_type'(i), v[i]);
      csr_valid <= 1'b0;
   endtask

   task automatic load_ntc_table(input table_style_t style);
      req_fields_t f;
      int          level;
      level = $urandom_range(200);
      for (int i = 0; i < NTC_ENTRIES; i++) begin
         f = random_fields();
         f.table_slot = SLOT_W'(i);
         case (style)
            TBL_SCRAMBLED: ;
            TBL_STEPPED: begin
               // runs of equal neighbours
               if ($urandom_range(2) != 0) level = level + $urandom_range(1, 90);
               if (level > RAW_MAX) level = RAW_MAX;
               f.table_word = RAW_W'(level);
            end
            default: begin
               level = level + $urandom_range(1, 60);
               if (level > RAW_MAX) level = RAW_MAX;
               f.table_word = RAW_W'(level);
            end
         endcase
         send_item(REQ_TABLE_WR, f);
      end
   endtask

   // Steady run: battery and thermistor held so the averages settle on a target
   task automatic send_run();
      int               len;
      logic [RAW_W-1:0] t_target, b_target;
      req_fields_t      f;
      len      = $urandom_range(8, 16);
      t_target = temp_near_entry();
      b_target = raw_near_mv(limit_copy[CSR_BATTERY_OVP + $urandom_range(2)]);
      for (int i = 0; i < len; i++) begin
         f = random_fields();
         f.temp_raw    = t_target;
         f.battery_raw = b_target;
         if ($urandom_range(1) != 0)
            f.charge_raw = raw_near_mv(limit_copy[$urandom_range(2)]);
         send_item(REQ_SAMPLE, f);
      end
   endtask

   task automatic random_burst();
      int          pick, n;
      req_fields_t f;
      pick = $urandom_range(99);
      if (pick < 5) begin
         f = random_fields();
         if ($urandom_range(3) != 0) f.table_slot[SLOT_W-1] = 1'b0;
         send_item(REQ_TABLE_WR, f);
      end else if (pick < 20) begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            f = random_fields();
            send_item(($urandom_range(9) == 0) ? REQ_TABLE_WR : REQ_SAMPLE, f);
         end
      end else begin
         send_run();
      end
   endtask

   task automatic set_idle(input idle_mode_t mode);
      case (mode)
         IDLE_SENDER_LIGHT: begin send_idle_pct = 30; recv_idle_pct = 78; end
         IDLE_SENDER_HEAVY: begin send_idle_pct = 78; recv_idle_pct = 30; end
         default:           begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested
   always @(posedge clock) begin
      if (hold_count > 0) begin
         hold_count = hold_count - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_trigger) begin
         hold_seen  = hold_trigger;
         hold_count = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Result checker against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_reading = reading_t'(rsp_tdata);
         if (pending_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with no reading expected, data %h", $realtime, rsp_tdata);
         end else begin
            wanted_reading = pending_readings.pop_front();
            if (seen_reading.charge_mv != wanted_reading.charge_mv ||
                seen_reading.charge_state != wanted_reading.charge_state ||
                seen_reading.battery_mv != wanted_reading.battery_mv ||
                seen_reading.battery_state != wanted_reading.battery_state ||
                seen_reading.charge_percent_x100 != wanted_reading.charge_percent_x100 ||
                seen_reading.temperature_c != wanted_reading.temperature_c ||
                seen_reading.pad != wanted_reading.pad) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: mismatch exp cmv=%0d cst=%0d bmv=%0d bst=%0d pct=%0d t=%0d pad=%0d",
                           $realtime, wanted_reading.charge_mv, wanted_reading.charge_state,
                           wanted_reading.battery_mv, wanted_reading.battery_state,
                           wanted_reading.charge_percent_x100,
                           $signed(wanted_reading.temperature_c), wanted_reading.pad);
                  $display("%0t:          got cmv=%0d cst=%0d bmv=%0d bst=%0d pct=%0d t=%0d pad=%0d",
                           $realtime, seen_reading.charge_mv, seen_reading.charge_state,
                           seen_reading.battery_mv, seen_reading.battery_state,
                           seen_reading.charge_percent_x100,
                           $signed(seen_reading.temperature_c), seen_reading.pad);
               end
            end
         end
      end
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

   // Main sequence
   initial begin
      req_fields_t f;
      reading_t    typed_reading;
      int          goal;
      set_idle(IDLE_SENDER_LIGHT);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // whole table first, so no sample can read an unwritten entry
      load_ntc_table(TBL_RISING);
      foreach (directed_rows[i]) begin
         f.charge_raw  = directed_rows[i].charge;
         f.battery_raw = directed_rows[i].batt;
         f.temp_raw    = directed_rows[i].temp;
         f.table_slot  = directed_rows[i].slot;
         f.table_word  = directed_rows[i].word;
         send_item(directed_rows[i].kind, f);
         if (directed_rows[i].typed) begin
            typed_reading = '0;
            typed_reading.charge_mv           = directed_rows[i].w_cmv;
            typed_reading.charge_state        = directed_rows[i].w_cst;
            typed_reading.battery_mv          = directed_rows[i].w_bmv;
            typed_reading.battery_state       = directed_rows[i].w_bst;
            typed_reading.charge_percent_x100 = directed_rows[i].w_pct;
            typed_reading.temperature_c       = directed_rows[i].w_temp;
            pending_readings[$] = typed_reading;
         end
      end
      wait_idle();

      // random phases, each with its own thresholds and idle pattern
      for (int phase = 0; phase < 6; phase++) begin
         program_limits(phase_limits[phase]);
         if (phase_tables[phase] != TBL_KEEP) load_ntc_table(phase_tables[phase]);
         set_idle(phase_idles[phase]);
         if (phase == 0 || phase == 4) hold_trigger++;
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) random_burst();
         wait_idle();
      end

      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
